>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define AAIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define AAIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/aair_pkg.sv
package aair_pkg;

    localparam int MAX_SRC_DIM_DEF = 256;
    localparam int MAX_DST_DIM_DEF = 4096;

    localparam int CFG_SRC_W = 9;
    localparam int CFG_DST_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RB    = 3'd4;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int PIX_W = 24;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  src_x;
        logic [7:0]  src_y;
        logic [31:0] pixel;
        logic [11:0] dst_x;
        logic [11:0] dst_y;
    } req_t;

    typedef struct packed {
        logic [15:0] red_mean;
        logic [15:0] green_mean;
        logic [15:0] blue_mean;
        logic        bad_request;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_WALK,
        ST_TAIL,
        ST_MEAN,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_X_LO,
        OP_X_HI,
        OP_Y_LO,
        OP_Y_HI,
        OP_RED,
        OP_GREEN,
        OP_BLUE
    } op_t;

endpackage

>>> src/aair_div.sv
module aair_div #(
    parameter int NW = 33,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dsr_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW:0]      trial;
    logic             fits;

    // Restoring division, one quotient bit a cycle.
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(trial - {1'b0, dsr_reg}) : trial[DW-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> src/aair_mem.sv
module aair_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [aair_pkg::PIX_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [aair_pkg::PIX_W-1:0] rdata
);
    import aair_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> src/area_average_image_resampler_top.sv
// A store does not leave idle, so the block stays ready for the next request. A query runs
// four span divisions and three mean divisions on one shared radix-2 divider (NW = 33
// at default sizes), plus one frame store read per pixel of the W x H source block.
// Out-of-range queries skip the divisions and the reads.
// Reset (rst_n, asynchronous, active low) clears control and loads register defaults;
// the frame store is not cleared and must be written before it is read.
module area_average_image_resampler_top #(
    parameter int MAX_SRC_DIM = aair_pkg::MAX_SRC_DIM_DEF,
    parameter int MAX_DST_DIM = aair_pkg::MAX_DST_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  aair_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output aair_pkg::rsp_t                rsp,
    input  logic                          cfg_we,
    input  logic [aair_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [aair_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import aair_pkg::*;

`include "assert_macros.svh"

    localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUMW  = CW + 8;
    localparam int NW    = (CW + 16 > 22) ? CW + 16 : 22;
    localparam int DVW   = (CW > CFG_DST_W) ? CW : CFG_DST_W;

    logic [CFG_SRC_W-1:0] src_w_reg, src_h_reg;
    logic [CFG_DST_W-1:0] dst_w_reg, dst_h_reg;
    logic                 swap_reg;

    logic [CFG_SRC_W-1:0] sw, sh;
    logic [CFG_DST_W-1:0] dw, dh;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   issue_reg, issue_next;

    logic [11:0]          dx_reg, dx_next, dy_reg, dy_next;
    logic [CFG_SRC_W-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [CFG_SRC_W-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [CFG_SRC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SUMW-1:0]      s0_reg, s0_next, s1_reg, s1_next, s2_reg, s2_next;
    logic [15:0]          m0_reg, m0_next, m1_reg, m1_next, m2_reg, m2_next;
    logic                 bad_reg, bad_next;
    logic                 rd_vld_reg;
    logic                 out_vld_reg;
    rsp_t                 out_reg;

    logic                 accept, query, bad_now, load_out;
    logic                 div_start, div_busy, div_done;
    logic [NW-1:0]        div_dividend, div_quotient;
    logic [DVW-1:0]       div_divisor;
    logic [12:0]          mul_a;
    logic [CFG_SRC_W-1:0] mul_b;
    logic [21:0]          span_prod;
    logic [CFG_SRC_W-1:0] q_span;
    logic [PIX_W-1:0]     rd_data;
    logic                 st_we;
    logic [AW-1:0]        st_waddr, rd_addr;

    function automatic logic [CFG_SRC_W-1:0] clamp_src(input logic [CFG_SRC_W-1:0] v);
        logic [CFG_SRC_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_SRC_W'(1);
        else if (32'(v) > 32'(MAX_SRC_DIM))
            r = CFG_SRC_W'(MAX_SRC_DIM);
        return r;
    endfunction

    function automatic logic [CFG_DST_W-1:0] clamp_dst(input logic [CFG_DST_W-1:0] v);
        logic [CFG_DST_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_DST_W'(1);
        else if (32'(v) > 32'(MAX_DST_DIM))
            r = CFG_DST_W'(MAX_DST_DIM);
        return r;
    endfunction

    assign sw = clamp_src(src_w_reg);
    assign sh = clamp_src(src_h_reg);
    assign dw = clamp_dst(dst_w_reg);
    assign dh = clamp_dst(dst_h_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_SRC_W'(256);
            src_h_reg <= CFG_SRC_W'(256);
            dst_w_reg <= CFG_DST_W'(1);
            dst_h_reg <= CFG_DST_W'(1);
            swap_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SRC_WIDTH:  src_w_reg <= cfg_wdata[CFG_SRC_W-1:0];
                CFG_SRC_HEIGHT: src_h_reg <= cfg_wdata[CFG_SRC_W-1:0];
                CFG_DST_WIDTH:  dst_w_reg <= cfg_wdata[CFG_DST_W-1:0];
                CFG_DST_HEIGHT: dst_h_reg <= cfg_wdata[CFG_DST_W-1:0];
                CFG_SWAP_RB:    swap_reg  <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign query     = accept && (req.cmd == CMD_QUERY);
    assign bad_now   = ({1'b0, req.dst_x} >= dw) || ({1'b0, req.dst_y} >= dh);
    assign load_out  = (state_reg == ST_FINISH) && (!out_vld_reg || rsp_ready);

    // Frame store: writes straight from the request, reads follow the walk.
    assign st_we    = accept && (req.cmd == CMD_STORE) &&
                      (32'(req.src_x) < 32'(MAX_SRC_DIM)) && (32'(req.src_y) < 32'(MAX_SRC_DIM));
    assign st_waddr = AW'(32'(req.src_y) * 32'(MAX_SRC_DIM) + 32'(req.src_x));
    assign rd_addr  = AW'(32'(y_reg) * 32'(MAX_SRC_DIM) + 32'(x_reg));

    aair_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(req.pixel[PIX_W-1:0]),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // Divider operand selection.
    always_comb
    begin
        mul_a        = 13'(dx_reg);
        mul_b        = sw;
        div_dividend = '0;
        div_divisor  = DVW'(dw);
        case (op_reg)
            OP_X_LO: mul_a = 13'(dx_reg);
            OP_X_HI: mul_a = 13'(dx_reg) + 13'd1;
            OP_Y_LO: mul_a = 13'(dy_reg);
            OP_Y_HI: mul_a = 13'(dy_reg) + 13'd1;
            default: mul_a = 13'(dx_reg);
        endcase
        if (op_reg == OP_Y_LO || op_reg == OP_Y_HI)
        begin
            mul_b       = sh;
            div_divisor = DVW'(dh);
        end
        case (op_reg)
            OP_RED:   div_dividend = NW'({s0_reg, 8'h00});
            OP_GREEN: div_dividend = NW'({s1_reg, 8'h00});
            OP_BLUE:  div_dividend = NW'({s2_reg, 8'h00});
            default:  div_dividend = NW'(span_prod);
        endcase
        if (op_reg == OP_RED || op_reg == OP_GREEN || op_reg == OP_BLUE)
            div_divisor = DVW'(cnt_reg);
    end

    assign span_prod = mul_a * mul_b;
    assign div_start = issue_reg && (state_reg == ST_SPAN || state_reg == ST_MEAN);
    assign q_span    = div_quotient[CFG_SRC_W-1:0];

    aair_div #(
        .NW(NW),
        .DW(DVW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .busy    (div_busy),
        .done    (div_done),
        .quotient(div_quotient)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (query)
                    state_next = bad_now ? ST_FINISH : ST_SPAN;
            ST_SPAN:
                if (div_done && op_reg == OP_Y_HI)
                    state_next = ST_WALK;
            ST_WALK:
                if (x_reg + 1'b1 == x1_reg && y_reg + 1'b1 == y1_reg)
                    state_next = ST_TAIL;
            ST_TAIL:
                state_next = ST_MEAN;
            ST_MEAN:
                if (div_done && op_reg == OP_BLUE)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (load_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        op_next    = op_reg;
        issue_next = 1'b0;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        cnt_next   = cnt_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        m0_next    = m0_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        bad_next   = bad_reg;

        if (rd_vld_reg)
        begin
            s0_next = s0_reg + SUMW'(rd_data[7:0]);
            s1_next = s1_reg + SUMW'(rd_data[15:8]);
            s2_next = s2_reg + SUMW'(rd_data[23:16]);
        end

        case (state_reg)
            ST_IDLE:
                if (query)
                begin
                    dx_next    = req.dst_x;
                    dy_next    = req.dst_y;
                    bad_next   = bad_now;
                    op_next    = OP_X_LO;
                    issue_next = !bad_now;
                    cnt_next   = '0;
                    s0_next    = '0;
                    s1_next    = '0;
                    s2_next    = '0;
                    m0_next    = '0;
                    m1_next    = '0;
                    m2_next    = '0;
                end
            ST_SPAN:
                if (div_done)
                begin
                    case (op_reg)
                        OP_X_LO: x0_next = q_span;
                        OP_X_HI: x1_next = (q_span > x0_reg) ? q_span : x0_reg + 1'b1;
                        OP_Y_LO: y0_next = q_span;
                        OP_Y_HI: y1_next = (q_span > y0_reg) ? q_span : y0_reg + 1'b1;
                        default: ;
                    endcase
                    x_next = x0_reg;
                    y_next = y0_reg;
                    if (op_reg == OP_Y_HI)
                    begin
                        op_next = OP_RED;
                    end
                    else
                    begin
                        op_next    = op_t'(op_reg + 3'd1);
                        issue_next = 1'b1;
                    end
                end
                else
                begin
                    issue_next = issue_reg && !div_start;
                end
            ST_WALK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (x_reg + 1'b1 == x1_reg)
                begin
                    x_next = x0_reg;
                    y_next = y_reg + 1'b1;
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            ST_TAIL:
                issue_next = 1'b1;
            ST_MEAN:
                if (div_done)
                begin
                    case (op_reg)
                        OP_RED:   m0_next = div_quotient[15:0];
                        OP_GREEN: m1_next = div_quotient[15:0];
                        OP_BLUE:  m2_next = div_quotient[15:0];
                        default:  ;
                    endcase
                    if (op_reg != OP_BLUE)
                    begin
                        op_next    = op_t'(op_reg + 3'd1);
                        issue_next = 1'b1;
                    end
                end
                else
                begin
                    issue_next = issue_reg && !div_start;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_X_LO;
            issue_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            issue_reg  <= issue_next;
            rd_vld_reg <= (state_reg == ST_WALK);
            if (load_out)
                out_vld_reg <= 1'b1;
            else if (rsp_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        x0_reg  <= x0_next;
        x1_reg  <= x1_next;
        y0_reg  <= y0_next;
        y1_reg  <= y1_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        m0_reg  <= m0_next;
        m1_reg  <= m1_next;
        m2_reg  <= m2_next;
        bad_reg <= bad_next;
        if (load_out)
        begin
            out_reg.red_mean    <= swap_reg ? m2_reg : m0_reg;
            out_reg.green_mean  <= m1_reg;
            out_reg.blue_mean   <= swap_reg ? m0_reg : m2_reg;
            out_reg.bad_request <= bad_reg;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    `AAIR_ASSERT(a_ready_idle, req_ready |-> (state_reg == ST_IDLE), "ready outside idle")
    `AAIR_ASSERT(a_div_free, div_start |-> !div_busy, "divider restarted while busy")
    `AAIR_ASSERT(a_rsp_from_finish, $rose(rsp_valid) |-> $past(state_reg == ST_FINISH),
        "result raised without finishing a query")
    `AAIR_ASSERT(a_bad_zero, (rsp_valid && rsp.bad_request) |->
        (rsp.red_mean == 16'd0 && rsp.green_mean == 16'd0 && rsp.blue_mean == 16'd0),
        "rejected query carries nonzero means")
    `AAIR_ASSERT_ALWAYS(a_walk_quiet, (!rst_n) |=> !rd_vld_reg, "read valid out of reset")
endmodule

>>> test/tb_area_average_image_resampler_top.sv
module tb_area_average_image_resampler_top;
    import aair_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 3000000;

    class area_mean_predictor;
        bit [23:0] pixels [65536];
        bit written [65536];
        logic [8:0] src_w_reg;
        logic [8:0] src_h_reg;
        logic [12:0] dst_w_reg;
        logic [12:0] dst_h_reg;
        bit swap_rb;
        rsp_t pending_means[$];
        bit [15:0] recent_stores[$];
        int mismatches;

        function new();
            src_w_reg = 9'd256;
            src_h_reg = 9'd256;
            dst_w_reg = 13'd1;
            dst_h_reg = 13'd1;
            swap_rb = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SRC_WIDTH:  src_w_reg = value[8:0];
                CFG_SRC_HEIGHT: src_h_reg = value[8:0];
                CFG_DST_WIDTH:  dst_w_reg = value[12:0];
                CFG_DST_HEIGHT: dst_h_reg = value[12:0];
                CFG_SWAP_RB:    swap_rb = value[0];
                default: ;
            endcase
        endfunction

        function int clamp_dim(int v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int src_w(); return clamp_dim(src_w_reg, MAX_SRC_DIM_DEF); endfunction
        function int src_h(); return clamp_dim(src_h_reg, MAX_SRC_DIM_DEF); endfunction
        function int dst_w(); return clamp_dim(dst_w_reg, MAX_DST_DIM_DEF); endfunction
        function int dst_h(); return clamp_dim(dst_h_reg, MAX_DST_DIM_DEF); endfunction

        function void span(int i, int s, int d, output int lo, output int hi);
            int b;
            lo = (i * s) / d;
            b = ((i + 1) * s) / d;
            hi = (b > lo + 1) ? b : lo + 1;
        endfunction

        function bit block_written(int dx, int dy);
            int x0, x1, y0, y1;
            span(dx, src_w(), dst_w(), x0, x1);
            span(dy, src_h(), dst_h(), y0, y1);
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++)
                    if (!written[y * 256 + x]) return 0;
            return 1;
        endfunction

        // Choose query coordinates that are out of range or whose source block holds only stored pixels.
        function req_t pick_query(req_t base);
            req_t r;
            int dx, dy, dw, dh, pick;
            r = base;
            r.cmd = CMD_QUERY;
            dw = dst_w();
            dh = dst_h();
            if (recent_stores.size() > 0 && dw >= src_w() && dh >= src_h()
                    && $urandom_range(0, 1)) begin
                pick = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
                if (pick[7:0] < src_w() && pick[15:8] < src_h()) begin
                    r.dst_x = 12'((pick[7:0] * dw + src_w() - 1) / src_w());
                    r.dst_y = 12'((pick[15:8] * dh + src_h() - 1) / src_h());
                    return r;
                end
            end
            for (int t = 0; t < 20; t++) begin
                if ($urandom_range(0, 9) == 0) begin
                    dx = $urandom_range(0, 4095);
                    dy = $urandom_range(0, 4095);
                end else begin
                    dx = $urandom_range(0, (dw + 1 > 4095) ? 4095 : dw + 1);
                    dy = $urandom_range(0, (dh + 1 > 4095) ? 4095 : dh + 1);
                end
                if (dx >= dw || dy >= dh || block_written(dx, dy)) begin
                    r.dst_x = 12'(dx);
                    r.dst_y = 12'(dy);
                    return r;
                end
            end
            // No safe query found: send a store instead.
            r.cmd = CMD_STORE;
            return r;
        endfunction

        function void note_request(req_t r);
            int x0, x1, y0, y1, idx;
            longint unsigned s_lo, s_mid, s_hi, count, m_lo, m_mid, m_hi;
            rsp_t e;
            if (r.cmd == CMD_STORE) begin
                idx = 32'({r.src_y, r.src_x});
                pixels[idx] = r.pixel[23:0];
                written[idx] = 1'b1;
                recent_stores.push_back(idx[15:0]);
                if (recent_stores.size() > 64) void'(recent_stores.pop_front());
                return;
            end
            e = '0;
            if (r.dst_x >= dst_w() || r.dst_y >= dst_h()) begin
                e.bad_request = 1'b1;
                pending_means.push_back(e);
                return;
            end
            span(r.dst_x, src_w(), dst_w(), x0, x1);
            span(r.dst_y, src_h(), dst_h(), y0, y1);
            s_lo = 0;
            s_mid = 0;
            s_hi = 0;
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++) begin
                    s_lo += pixels[y * 256 + x][7:0];
                    s_mid += pixels[y * 256 + x][15:8];
                    s_hi += pixels[y * 256 + x][23:16];
                end
            count = (x1 - x0) * (y1 - y0);
            m_lo = (s_lo << 8) / count;
            m_mid = (s_mid << 8) / count;
            m_hi = (s_hi << 8) / count;
            e.red_mean = swap_rb ? m_hi[15:0] : m_lo[15:0];
            e.green_mean = m_mid[15:0];
            e.blue_mean = swap_rb ? m_lo[15:0] : m_hi[15:0];
            pending_means.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (pending_means.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: red %h green %h blue %h bad %b",
                             got.red_mean, got.green_mean, got.blue_mean, got.bad_request);
                return;
            end
            e = pending_means.pop_front();
            if (got.red_mean !== e.red_mean || got.green_mean !== e.green_mean ||
                    got.blue_mean !== e.blue_mean || got.bad_request !== e.bad_request) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %h %h %h %b, got %h %h %h %b",
                             e.red_mean, e.green_mean, e.blue_mean, e.bad_request,
                             got.red_mean, got.green_mean, got.blue_mean, got.bad_request);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    area_mean_predictor means;
    bit steady;
    bit hold_off_now;
    int cycles;

    area_average_image_resampler_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_now)
            begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off_now = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(negedge clk); while (!rsp_valid);
        end
    end

    // Check each result at the falling edge before its transfer edge.
    always @(negedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            means.check_result(rsp);
    end

    task automatic send(req_t r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(negedge clk); while (!req_ready);
        means.note_request(r);
        @(posedge clk);
    endtask

    function automatic req_t random_fields();
        req_t r;
        r.cmd = 1'($urandom_range(0, 1));
        r.src_x = 8'($urandom_range(0, 255));
        r.src_y = 8'($urandom_range(0, 255));
        r.pixel = $urandom;
        r.dst_x = 12'($urandom_range(0, 4095));
        r.dst_y = 12'($urandom_range(0, 4095));
        return r;
    endfunction

    function automatic req_t store_at(int x, int y, logic [31:0] value);
        req_t r;
        r = random_fields();
        r.cmd = CMD_STORE;
        r.src_x = 8'(x);
        r.src_y = 8'(y);
        r.pixel = value;
        return r;
    endfunction

    function automatic req_t query_at(int x, int y);
        req_t r;
        r = random_fields();
        r.cmd = CMD_QUERY;
        r.dst_x = 12'(x);
        r.dst_y = 12'(y);
        return r;
    endfunction

    // Wait for the block to drain before touching registers.
    task automatic settle();
        req_valid <= 1'b0;
        while (means.pending_means.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(int sw, int sh, int dw, int dh, int swap_rb);
        logic [CFG_IDX_W-1:0] idx [5];
        int vals [5];
        idx = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH, CFG_DST_HEIGHT, CFG_SWAP_RB};
        vals = '{sw, sh, dw, dh, swap_rb};
        settle();
        for (int k = 0; k < 5; k++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= idx[k];
            cfg_wdata <= CFG_DATA_W'(vals[k]);
            means.write_reg(idx[k], CFG_DATA_W'(vals[k]));
            @(posedge clk);
        end
        // Unknown index: must change nothing.
        cfg_idx <= CFG_UNUSED;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fill_frame();
        for (int y = 0; y < means.src_h(); y++)
            for (int x = 0; x < means.src_w(); x++)
                send(store_at(x, y, $urandom));
    endtask

    task automatic random_items(int n);
        req_t r;
        for (int k = 0; k < n; k++)
        begin
            r = random_fields();
            if ($urandom_range(0, 99) < 45)
            begin
                r.cmd = CMD_STORE;
                if ($urandom_range(0, 4) != 0)
                begin
                    r.src_x = 8'($urandom_range(0, means.src_w() - 1));
                    r.src_y = 8'($urandom_range(0, means.src_h() - 1));
                end
            end
            else
                r = means.pick_query(r);
            send(r);
        end
    endtask

    initial
    begin
        means = new();
        steady = 1'b0;
        hold_off_now = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, edge queries, store outside the frame.
        configure(4, 3, 2, 2, 0);
        send(store_at(0, 0, 32'hFFFF_FFFF));
        send(store_at(1, 0, 32'h0000_0000));
        send(store_at(2, 0, 32'h00FF_FFFF));
        send(store_at(3, 0, 32'hFF00_0000));
        send(store_at(0, 1, 32'h0000_00FF));
        send(store_at(1, 1, 32'h0000_FF00));
        send(store_at(2, 1, 32'h00FF_0000));
        send(store_at(3, 1, 32'h1234_5678));
        send(store_at(0, 2, 32'h0101_0101));
        send(store_at(1, 2, 32'hFEFE_FEFE));
        send(store_at(2, 2, 32'h8000_0080));
        send(store_at(3, 2, 32'h7F7F_7F7F));
        send(store_at(255, 255, 32'hAAAA_AAAA));
        send(query_at(0, 0));
        send(query_at(1, 0));
        send(query_at(0, 1));
        send(query_at(1, 1));
        send(query_at(2, 0));
        send(query_at(0, 2));
        send(query_at(4095, 4095));
        random_items(150);

        // Single pixel with red and blue swapped, no idling.
        configure(1, 1, 1, 1, 1);
        steady = 1'b1;
        send(query_at(0, 0));
        send(query_at(1, 0));
        random_items(120);
        steady = 1'b0;

        configure(16, 16, 5, 3, 1);
        fill_frame();
        random_items(250);

        // Largest source and output sizes.
        configure(256, 256, 4096, 4096, 0);
        send(store_at(255, 255, $urandom));
        send(query_at(4095, 4095));
        random_items(50);

        // Out-of-range register values: zero acts as one, large ones saturate.
        configure(0, 300, 5000, 0, 1);
        random_items(250);

        configure(7, 13, 3, 20, 1);
        fill_frame();
        random_items(250);

        // Whole frame in one block; receiver holds off so that queries stall at the result output.
        configure(8, 8, 1, 1, 0);
        fill_frame();
        hold_off_now = 1'b1;
        random_items(250);

        settle();
        repeat (50) @(posedge clk);
        if (means.mismatches == 0 && means.pending_means.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> area_average_image_resampler_top.f
+incdir+src
src/aair_pkg.sv
src/aair_div.sv
src/aair_mem.sv
src/area_average_image_resampler_top.sv
test/tb_area_average_image_resampler_top.sv
